// ----- hdl/deq_pkg.sv -----
// Shared types, widths and codes for the double-ended queue.
package deq_pkg;

  // Default geometry of the ring store
  localparam int unsigned DepthDef     = 256;
  localparam int unsigned DataWidthDef = 32;

  // Fixed widths of the request and response fields
  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 9;

  // Request codes
  typedef enum logic [ReqTypeW-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_READ       = 2'd2
  } req_e;

  // Status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One response transaction
  typedef struct packed {
    logic [ValueW-1:0] read_data;
    status_e           status;
    logic [CountW-1:0] element_count;
    logic              is_empty;
    logic [ValueW-1:0] front_value;
    logic [ValueW-1:0] back_value;
  } result_t;

endpackage

// ----- hdl/deq_req_if.sv -----
// Request channel: valid/ready handshake with the request payload.
interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::ReqTypeW-1:0]  req_type;
  logic [deq_pkg::ValueW-1:0]    item_value;
  logic [deq_pkg::IndexW-1:0]    read_index;

  modport source (output valid, output req_type, output item_value, output read_index,
                  input ready);
  modport sink (input valid, input req_type, input item_value, input read_index,
                output ready);
endinterface

// ----- hdl/deq_rsp_if.sv -----
// Response channel: valid/ready handshake with the response payload.
interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::ValueW-1:0]    read_data;
  logic [deq_pkg::StatusW-1:0]   status;
  logic [deq_pkg::CountW-1:0]    element_count;
  logic                          is_empty;
  logic [deq_pkg::ValueW-1:0]    front_value;
  logic [deq_pkg::ValueW-1:0]    back_value;

  modport source (output valid, output read_data, output status, output element_count,
                  output is_empty, output front_value, output back_value, input ready);
  modport sink (input valid, input read_data, input status, input element_count,
                input is_empty, input front_value, input back_value, output ready);
endinterface

// ----- hdl/deq_out_stage.sv -----
// Output register of the queue: holds one response until the receiver takes it.
module deq_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  deq_pkg::result_t  s_data_i,
  deq_rsp_if.source         rsp_o
);

  logic             valid_q;
  deq_pkg::result_t data_q;

  // Take a new response when empty or when the held one leaves this cycle
  assign s_ready_o = !valid_q || rsp_o.ready;

  // Control: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  // Payload: load on each transaction in
  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= s_data_i;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.read_data     = data_q.read_data;
  assign rsp_o.status        = data_q.status;
  assign rsp_o.element_count = data_q.element_count;
  assign rsp_o.is_empty      = data_q.is_empty;
  assign rsp_o.front_value   = data_q.front_value;
  assign rsp_o.back_value    = data_q.back_value;

endmodule

// ----- hdl/double_ended_queue_core.sv -----
// Top level of the double-ended queue over a ring store.
//
// Requests enter on req_i: push at front, push at back, or read by logical
// index from the front. Each request transaction yields exactly one response
// transaction on rsp_o with the read data, a status (ok, index out of range,
// full push dropped), the element count after the request, an empty flag and
// the front and back values (zero when empty).
// Each response passes through the read stage (with the registered store read)
// and then the output register.
// Throughput: one request per cycle while rsp_o is not stalled; head, count
// and the front and back copies update at the request edge, and the store
// takes one write and one registered read per cycle.
// Reset empties the queue at once (head, count and copies cleared); store
// contents are not cleared and are only ever read inside the stored count.
// When the receiver stalls, the output register and the read stage fill and
// then req_i.ready drops; no response is lost or repeated.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = deq_pkg::DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  localparam int unsigned PtrW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > deq_pkg::IndexW) ? CntW : deq_pkg::IndexW;
  localparam logic [PtrW:0] DepthW = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  // Queue state
  logic [PtrW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;

  // Store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_rd_q;
  logic                  wr_en;
  logic [PtrW-1:0]       wr_addr;
  logic                  rd_en;
  logic [PtrW-1:0]       rd_addr;

  // Read stage
  logic                    s1_valid_q;
  logic                    s1_rd_ok_q;
  deq_pkg::status_e        s1_status_q;
  logic [deq_pkg::CountW-1:0] s1_count_q;
  logic                    s1_empty_q;
  logic [deq_pkg::ValueW-1:0] s1_front_q;
  logic [deq_pkg::ValueW-1:0] s1_back_q;

  logic                    out_ready;
  logic                    accept;
  deq_pkg::req_e           req;
  deq_pkg::status_e        status_d;
  logic                    rd_ok;
  logic [DATA_WIDTH-1:0]   val;
  logic [CmpW-1:0]         idx_ext;
  logic [CmpW-1:0]         cnt_ext;
  logic [PtrW:0]           rd_sum;
  logic [PtrW:0]           back_sum;
  logic [PtrW-1:0]         head_dec;
  logic [deq_pkg::ValueW-1:0] front_ext, back_ext, rd_ext;
  deq_pkg::result_t        s1_result;

  // Fit the request value to the store width
  if (DATA_WIDTH <= deq_pkg::ValueW) begin : g_val_narrow
    assign val       = req_i.item_value[DATA_WIDTH-1:0];
    assign front_ext = deq_pkg::ValueW'(front_d);
    assign back_ext  = deq_pkg::ValueW'(back_d);
    assign rd_ext    = deq_pkg::ValueW'(mem_rd_q);
  end else begin : g_val_wide
    assign val       = DATA_WIDTH'(req_i.item_value);
    assign front_ext = front_d[deq_pkg::ValueW-1:0];
    assign back_ext  = back_d[deq_pkg::ValueW-1:0];
    assign rd_ext    = mem_rd_q[deq_pkg::ValueW-1:0];
  end

  // Advance when the read stage is empty or moves on this cycle
  assign req_i.ready = !s1_valid_q || out_ready;
  assign accept      = req_i.valid && req_i.ready;
  assign req         = deq_pkg::req_e'(req_i.req_type);

  // Ring address arithmetic: one compare and subtract wraps each sum
  assign idx_ext  = CmpW'(req_i.read_index);
  assign cnt_ext  = CmpW'(count_q);
  assign rd_sum   = (PtrW + 1)'(head_q) + (PtrW + 1)'(idx_ext[PtrW-1:0]);
  assign back_sum = (PtrW + 1)'(head_q) + (PtrW + 1)'(count_q[PtrW-1:0]);
  assign head_dec = (head_q == '0) ? PtrW'(DEPTH - 1) : head_q - 1'b1;

  // Decode the request and compute the next queue state
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    status_d = deq_pkg::ST_OK;
    rd_ok    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = head_dec;
    rd_addr  = (rd_sum >= DepthW) ? PtrW'(rd_sum - DepthW) : rd_sum[PtrW-1:0];
    case (req)
      deq_pkg::REQ_PUSH_FRONT: begin
        if (count_q >= DepthCnt) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          front_d = val;
          if (count_q == '0) begin
            back_d = val;
          end
          count_d = count_q + 1'b1;
        end
      end
      deq_pkg::REQ_PUSH_BACK: begin
        if (count_q >= DepthCnt) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = (back_sum >= DepthW) ? PtrW'(back_sum - DepthW) : back_sum[PtrW-1:0];
          back_d  = val;
          if (count_q == '0) begin
            front_d = val;
          end
          count_d = count_q + 1'b1;
        end
      end
      deq_pkg::REQ_READ: begin
        if (idx_ext < cnt_ext) begin
          rd_ok = 1'b1;
        end else begin
          status_d = deq_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en = accept && rd_ok;

  // Queue state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      front_q <= '0;
      back_q  <= '0;
    end else if (accept) begin
      head_q  <= head_d;
      count_q <= count_d;
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  // Store: one write and one registered read per cycle; read data holds on stall
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= val;
    end
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_ok_q  <= rd_ok;
      s1_status_q <= status_d;
      s1_count_q  <= deq_pkg::CountW'(count_d);
      s1_empty_q  <= (count_d == '0);
      s1_front_q  <= (count_d == '0) ? '0 : front_ext;
      s1_back_q   <= (count_d == '0) ? '0 : back_ext;
    end
  end

  // Assemble the response; drop the store data unless the read was in range
  always_comb begin
    s1_result.read_data     = s1_rd_ok_q ? rd_ext : '0;
    s1_result.status        = s1_status_q;
    s1_result.element_count = s1_count_q;
    s1_result.is_empty      = s1_empty_q;
    s1_result.front_value   = s1_front_q;
    s1_result.back_value    = s1_back_q;
  end

  deq_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s1_valid_q),
    .s_ready_o (out_ready),
    .s_data_i  (s1_result),
    .rsp_o     (rsp_o)
  );

endmodule
